/* rtl/core/pixel_channel_calibrator_defines.svh */
// Assertion macros for the pixel channel calibrator.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef PIXEL_CHANNEL_CALIBRATOR_DEFINES_SVH
`define PIXEL_CHANNEL_CALIBRATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pcc_pkg.sv */
// Shared constants and the alpha blend function of the pixel channel calibrator.
// No dependencies.
package pcc_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned IN_DATA_W  = 2 * POS_W + 4 * CHAN_W;
  localparam int unsigned OUT_DATA_W = 4 * CHAN_W;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREVIEW = 2'd2;

  localparam logic [CNT_W-1:0] CNT_PASS  = 3'd0;
  localparam logic [CNT_W-1:0] CNT_GRAY  = 3'd1;
  localparam logic [CNT_W-1:0] CNT_GA    = 3'd2;
  localparam logic [CNT_W-1:0] CNT_RGB   = 3'd3;
  localparam logic [CNT_W-1:0] CNT_RGBA  = 3'd4;
  localparam logic [CNT_W-1:0] CNT_MANY  = 3'd5;

  localparam logic [CHAN_W-1:0] CHECK_DARK   = 8'd96;
  localparam logic [CHAN_W-1:0] CHECK_LIGHT  = 8'd160;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam int unsigned       CHECK_BIT    = 3;

  // floor(n/3) == (n * 683) >> 11 for every n below 2045
  localparam logic [9:0]  GRAY_RECIP = 10'd683;
  localparam int unsigned GRAY_SHIFT = 11;

  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] v,
                                              input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] i);
    logic [15:0] pv;
    logic [15:0] pi;
    logic [16:0] sum;
    pv  = {8'd0, v} * {8'd0, a};
    pi  = {8'd0, ALPHA_OPAQUE - a} * {8'd0, i};
    sum = {1'b0, pv} + {1'b0, pi};
    return sum[15:8];
  endfunction

endpackage

/* rtl/core/pixel_channel_calibrator.sv */
// Pixel channel calibrator: channel count conversion with checkerboard preview.
// Depends on pcc_pkg and pixel_channel_calibrator_defines.svh.
//
// Usage:
//   s_* carries one pixel per transaction: position and four 8-bit channels.
//   m_* returns the converted pixel, unused channels zero.
//   cfg_we/cfg_index/cfg_data write target_channels (0), source_channels (1)
//   and preview_blend (2); write only while the block is idle.
// Timing:
//   Two register stages: the first holds the pixel, the checker square and
//   the gray value (sum times reciprocal of three); the second holds the
//   blended, remapped result and drives m_tvalid. Throughput is one pixel
//   per cycle while m_tready stays high. The blend multipliers sit between
//   the stages.
// Stall:
//   When m_tready is low the result holds and an empty first stage still
//   takes one more pixel; s_tready drops only when both stages are full.
// Reset:
//   rst clears both stages and loads target_channels 0, source_channels 4,
//   preview_blend 0.
`include "pixel_channel_calibrator_defines.svh"

module pixel_channel_calibrator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, chan0, chan1, chan2, chan3
  input  logic [pcc_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out0, out1, out2, out3
  output logic [pcc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pcc_pkg::CNT_W-1:0] target_channels;
  logic [pcc_pkg::CNT_W-1:0] source_channels;
  logic                      preview_blend;

  logic                        p_valid;
  logic [pcc_pkg::CHAN_W-1:0]  p_c0, p_c1, p_c2, p_c3, p_gray;
  logic                        p_light;

  logic                        en_out;
  logic                        en_pix;

  logic [9:0]                  sum10;
  logic [19:0]                 gray_prod;
  logic [pcc_pkg::CHAN_W-1:0]  gray_next;

  logic [pcc_pkg::CNT_W-1:0]   src;
  logic [pcc_pkg::CHAN_W-1:0]  ck;
  logic [pcc_pkg::CHAN_W-1:0]  b0_v, b0_a, b0, b1, b2;
  logic [pcc_pkg::CHAN_W-1:0]  o0, o1, o2, o3;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_channels <= pcc_pkg::CNT_PASS;
      source_channels <= pcc_pkg::CNT_RGBA;
      preview_blend   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pcc_pkg::REG_TARGET:  target_channels <= cfg_data;
        pcc_pkg::REG_SOURCE:  source_channels <= cfg_data;
        pcc_pkg::REG_PREVIEW: preview_blend   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en_out   = !m_tvalid || m_tready;
  assign en_pix   = !p_valid || en_out;
  assign s_tready = en_pix;

  assign sum10     = {2'd0, s_tdata[39:32]} + {2'd0, s_tdata[47:40]} + {2'd0, s_tdata[55:48]};
  assign gray_prod = {10'd0, sum10} * {10'd0, pcc_pkg::GRAY_RECIP};
  assign gray_next = gray_prod[pcc_pkg::GRAY_SHIFT +: pcc_pkg::CHAN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en_pix) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_pix && s_tvalid) begin
      p_c0    <= s_tdata[39:32];
      p_c1    <= s_tdata[47:40];
      p_c2    <= s_tdata[55:48];
      p_c3    <= s_tdata[63:56];
      p_gray  <= gray_next;
      p_light <= s_tdata[pcc_pkg::CHECK_BIT] ^ s_tdata[pcc_pkg::POS_W + pcc_pkg::CHECK_BIT];
    end
  end

  always_comb begin
    src = pcc_pkg::CNT_MANY;
    if (source_channels inside {[pcc_pkg::CNT_GRAY:pcc_pkg::CNT_RGBA]}) begin
      src = source_channels;
    end
  end

  assign ck   = p_light ? pcc_pkg::CHECK_LIGHT : pcc_pkg::CHECK_DARK;
  assign b0_v = (target_channels == pcc_pkg::CNT_GRAY && src == pcc_pkg::CNT_RGBA) ?
                p_gray : p_c0;
  assign b0_a = (src == pcc_pkg::CNT_GA) ? p_c1 : p_c3;
  assign b0   = pcc_pkg::blend(b0_v, b0_a, ck);
  assign b1   = pcc_pkg::blend(p_c1, p_c3, ck);
  assign b2   = pcc_pkg::blend(p_c2, p_c3, ck);

  always_comb begin
    o0 = p_c0;
    o1 = '0;
    o2 = '0;
    o3 = '0;
    case (target_channels)
      pcc_pkg::CNT_GRAY: begin
        case (src)
          pcc_pkg::CNT_GA:   o0 = preview_blend ? b0 : p_c0;
          pcc_pkg::CNT_RGB:  o0 = p_gray;
          pcc_pkg::CNT_RGBA: o0 = preview_blend ? b0 : p_gray;
          default:           o0 = p_c0;
        endcase
      end
      pcc_pkg::CNT_GA: begin
        case (src)
          pcc_pkg::CNT_GRAY: o1 = pcc_pkg::ALPHA_OPAQUE;
          pcc_pkg::CNT_RGB: begin
            o0 = p_gray;
            o1 = pcc_pkg::ALPHA_OPAQUE;
          end
          pcc_pkg::CNT_RGBA: begin
            o0 = p_gray;
            o1 = p_c3;
          end
          default:           o1 = p_c1;
        endcase
      end
      pcc_pkg::CNT_RGB: begin
        if (src == pcc_pkg::CNT_GRAY) begin
          o1 = p_c0;
          o2 = p_c0;
        end else if (src == pcc_pkg::CNT_GA) begin
          o0 = preview_blend ? b0 : p_c0;
          o1 = o0;
          o2 = o0;
        end else if (src == pcc_pkg::CNT_RGBA && preview_blend) begin
          o0 = b0;
          o1 = b1;
          o2 = b2;
        end else begin
          o1 = p_c1;
          o2 = p_c2;
        end
      end
      pcc_pkg::CNT_RGBA: begin
        case (src)
          pcc_pkg::CNT_GRAY: begin
            o1 = p_c0;
            o2 = p_c0;
            o3 = pcc_pkg::ALPHA_OPAQUE;
          end
          pcc_pkg::CNT_GA: begin
            o1 = p_c0;
            o2 = p_c0;
            o3 = p_c1;
          end
          pcc_pkg::CNT_RGB: begin
            o1 = p_c1;
            o2 = p_c2;
            o3 = pcc_pkg::ALPHA_OPAQUE;
          end
          default: begin
            o1 = p_c1;
            o2 = p_c2;
            o3 = p_c3;
          end
        endcase
      end
      default: begin
        if (src >= pcc_pkg::CNT_GA)   o1 = p_c1;
        if (src >= pcc_pkg::CNT_RGB)  o2 = p_c2;
        if (src >= pcc_pkg::CNT_RGBA) o3 = p_c3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && p_valid) begin
      m_tdata <= {o3, o2, o1, o0};
    end
  end

  `PCC_ASSERT_NEXT(a_accept_fills_stage, s_tvalid && s_tready, p_valid, "pixel lost")
  `PCC_ASSERT_NEXT(a_stage_moves_out, p_valid && en_out, m_tvalid, "stage one stuck")
  `PCC_ASSERT_SAME(a_ready_only_when_full, !s_tready, p_valid && !en_out, "stall with free stage")

endmodule
